/* rtl/nnlsgp_pkg.sv */
// Shared types, constants and helpers for the nonnegative least-squares unmixer.
`timescale 1ns / 1ps
`default_nettype none
package nnlsgp_pkg;

  localparam int MAX_COMPONENTS  = 8;
  localparam int MAX_WAVELENGTHS = 64;

  // Index and count widths.
  localparam int KW   = (MAX_COMPONENTS > 1) ? $clog2(MAX_COMPONENTS) : 1;
  localparam int KCW  = $clog2(MAX_COMPONENTS + 1);
  localparam int WLW  = (MAX_WAVELENGTHS > 1) ? $clog2(MAX_WAVELENGTHS) : 1;
  localparam int WLCW = $clog2(MAX_WAVELENGTHS + 1);

  localparam int MIX_DEPTH  = MAX_WAVELENGTHS * MAX_COMPONENTS;
  localparam int GRAM_DEPTH = MAX_COMPONENTS * MAX_COMPONENTS;
  localparam int PINV_DEPTH = MAX_COMPONENTS * MAX_WAVELENGTHS;
  localparam int MIX_AW  = (MIX_DEPTH > 1) ? $clog2(MIX_DEPTH) : 1;
  localparam int GRAM_AW = (GRAM_DEPTH > 1) ? $clog2(GRAM_DEPTH) : 1;
  localparam int PINV_AW = (PINV_DEPTH > 1) ? $clog2(PINV_DEPTH) : 1;

  // Correlation, start solution and gradient all fit in this signed width:
  // each accumulated term is below 2^34 in magnitude.
  localparam int GRAD_W = 37 + WLW + 1;
  // Shared multiplier: GRAD_W signed by 33 signed.
  localparam int MB_W = 33;
  localparam int PW   = GRAD_W + MB_W;
  // Width of the step delta; the unclipped new solution has one bit more.
  localparam int DW   = GRAD_W + 9;
  localparam int ABW  = 31;
  localparam int CFG_AW = 3;

  typedef enum logic [1:0] {
    ACT_LOAD_MIX  = 2'd0,
    ACT_LOAD_GRAM = 2'd1,
    ACT_LOAD_PINV = 2'd2,
    ACT_SAMPLE    = 2'd3
  } action_e;

  typedef enum logic [CFG_AW-1:0] {
    REG_COMPONENT_COUNT  = 3'd0,
    REG_WAVELENGTH_COUNT = 3'd1,
    REG_STEP_RECIPROCAL  = 3'd2,
    REG_GAP_TOLERANCE    = 3'd3,
    REG_ITERATION_LIMIT  = 3'd4
  } reg_index_e;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_SMP_RD,
    ST_SMP_MA,
    ST_SMP_MP,
    ST_SMP_ACC,
    ST_CLIP,
    ST_GR_RD,
    ST_GR_MUL,
    ST_GR_ACC,
    ST_GAP_A,
    ST_GAP_B,
    ST_GAP_C,
    ST_CHECK,
    ST_STEP_A,
    ST_STEP_B,
    ST_STEP_C,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic [1:0]         action;
    logic [9:0]         entry_row;
    logic [9:0]         entry_col;
    logic signed [31:0] coef_value;
    logic signed [31:0] sample_value;
  } in_req_t;

  typedef struct packed {
    logic [ABW-1:0] abundance;
    logic [5:0]     component_index;
    logic           last_component;
    logic           converged;
    logic [15:0]    iterations_used;
  } out_res_t;

  localparam logic signed [DW:0] ABUND_MAX = (DW+1)'(64'sd2147483647);

  // Saturate a signed value into the abundance range [0, 2^31-1].
  function automatic logic [ABW-1:0] clip_abund(input logic signed [DW:0] v);
    logic [ABW-1:0] r;
    if (v < 0) begin
      r = '0;
    end else if (v > ABUND_MAX) begin
      r = '1;
    end else begin
      r = v[ABW-1:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

/* rtl/nnls_gradient_projection.sv */
// Top level of the projected-gradient nonnegative least-squares unmixer.
// One shared multiplier under a sequencer does all the work. A load is written
// in the idle state. Each sample steps through read, two multiplies and an
// accumulate for each of the k components; the last sample of a pixel then
// clips the start solution, computes the first gradient, gap and convergence
// check, and runs further step, gradient, gap and check iterations, bounded by
// the iteration limit; the k results follow, one per cycle while not stalled.
// Input is stalled while a sample or its results are being worked on.
`timescale 1ns / 1ps
`default_nettype none
module nnls_gradient_projection (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 cfg_we_i,
  input  wire logic [nnlsgp_pkg::CFG_AW-1:0]        cfg_index_i,
  input  wire logic [31:0]                          cfg_wdata_i,
  input  wire logic                                 in_valid_i,
  output logic                                      in_stall_o,
  input  wire nnlsgp_pkg::in_req_t                  in_req_i,
  output logic                                      out_valid_o,
  input  wire logic                                 out_stall_i,
  output nnlsgp_pkg::out_res_t                      out_res_o
);

  localparam int KW     = nnlsgp_pkg::KW;
  localparam int KCW    = nnlsgp_pkg::KCW;
  localparam int WLW    = nnlsgp_pkg::WLW;
  localparam int WLCW   = nnlsgp_pkg::WLCW;
  localparam int GRAD_W = nnlsgp_pkg::GRAD_W;
  localparam int PW     = nnlsgp_pkg::PW;
  localparam int MB_W   = nnlsgp_pkg::MB_W;
  localparam int DW     = nnlsgp_pkg::DW;
  localparam int MAXK   = nnlsgp_pkg::MAX_COMPONENTS;
  localparam int MAXWL  = nnlsgp_pkg::MAX_WAVELENGTHS;

  // Configuration registers.
  logic [6:0]  comp_count_q;
  logic [10:0] wl_count_q;
  logic [31:0] step_recip_q;
  logic [31:0] gap_tol_q;
  logic [15:0] iter_limit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      comp_count_q <= 7'd8;
      wl_count_q   <= 11'd64;
      step_recip_q <= 32'd16777216;
      gap_tol_q    <= 32'd66;
      iter_limit_q <= 16'd100;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        nnlsgp_pkg::REG_COMPONENT_COUNT:  comp_count_q <= cfg_wdata_i[6:0];
        nnlsgp_pkg::REG_WAVELENGTH_COUNT: wl_count_q   <= cfg_wdata_i[10:0];
        nnlsgp_pkg::REG_STEP_RECIPROCAL:  step_recip_q <= cfg_wdata_i;
        nnlsgp_pkg::REG_GAP_TOLERANCE:    gap_tol_q    <= cfg_wdata_i;
        nnlsgp_pkg::REG_ITERATION_LIMIT:  iter_limit_q <= cfg_wdata_i[15:0];
        default: ;
      endcase
    end
  end

  // Clamped counts.
  logic [KCW-1:0]  k_eff;
  logic [WLCW-1:0] wl_eff;
  always_comb begin
    if (comp_count_q == 7'd0) begin
      k_eff = KCW'(1);
    end else if (comp_count_q > 7'(MAXK)) begin
      k_eff = KCW'(MAXK);
    end else begin
      k_eff = comp_count_q[KCW-1:0];
    end
    if (wl_count_q == 11'd0) begin
      wl_eff = WLCW'(1);
    end else if (wl_count_q > 11'(MAXWL)) begin
      wl_eff = WLCW'(MAXWL);
    end else begin
      wl_eff = wl_count_q[WLCW-1:0];
    end
  end

  nnlsgp_pkg::state_e state_q, state_d;
  logic [KW-1:0]  c_q, d_q;
  logic [WLCW-1:0] smp_q;
  logic [WLW-1:0] w_q;
  logic [15:0]    iter_q;
  logic           conv_q;

  // Payload registers.
  logic signed [31:0]       s_q;
  logic signed [GRAD_W-1:0] corr_q [MAXK];
  logic signed [GRAD_W-1:0] sol_q  [MAXK];
  logic signed [GRAD_W-1:0] grad_q [MAXK];
  logic signed [GRAD_W-1:0] acc_q;
  logic [63:0]              gap_q;
  logic [63:0]              thi_q;
  logic signed [DW-1:0]     dh_q;
  logic signed [PW-1:0]     prod_q;

  // Coefficient memories.
  logic signed [31:0] mix_mem  [nnlsgp_pkg::MIX_DEPTH];
  logic signed [31:0] gram_mem [nnlsgp_pkg::GRAM_DEPTH];
  logic signed [31:0] pinv_mem [nnlsgp_pkg::PINV_DEPTH];
  logic signed [31:0] mix_rd_q, gram_rd_q, pinv_rd_q;

  logic in_acc, out_acc;
  assign in_acc  = in_valid_i && !in_stall_o;
  assign out_acc = out_valid_o && !out_stall_i;

  logic [nnlsgp_pkg::MIX_AW-1:0]  mix_waddr, mix_raddr;
  logic [nnlsgp_pkg::GRAM_AW-1:0] gram_waddr, gram_raddr;
  logic [nnlsgp_pkg::PINV_AW-1:0] pinv_waddr, pinv_raddr;
  assign mix_waddr  = nnlsgp_pkg::MIX_AW'(in_req_i.entry_row * MAXK + in_req_i.entry_col);
  assign gram_waddr = nnlsgp_pkg::GRAM_AW'(in_req_i.entry_row * MAXK + in_req_i.entry_col);
  assign pinv_waddr = nnlsgp_pkg::PINV_AW'(in_req_i.entry_row * MAXWL + in_req_i.entry_col);
  assign mix_raddr  = nnlsgp_pkg::MIX_AW'(w_q * MAXK + c_q);
  assign gram_raddr = nnlsgp_pkg::GRAM_AW'(c_q * MAXK + d_q);
  assign pinv_raddr = nnlsgp_pkg::PINV_AW'(c_q * MAXWL + w_q);

  logic mix_we, gram_we, pinv_we;
  assign mix_we  = in_acc && in_req_i.action == nnlsgp_pkg::ACT_LOAD_MIX
                   && in_req_i.entry_row < 10'(MAXWL) && in_req_i.entry_col < 10'(MAXK);
  assign gram_we = in_acc && in_req_i.action == nnlsgp_pkg::ACT_LOAD_GRAM
                   && in_req_i.entry_row < 10'(MAXK) && in_req_i.entry_col < 10'(MAXK);
  assign pinv_we = in_acc && in_req_i.action == nnlsgp_pkg::ACT_LOAD_PINV
                   && in_req_i.entry_row < 10'(MAXK) && in_req_i.entry_col < 10'(MAXWL);

  always_ff @(posedge clk_i) begin
    if (mix_we) begin
      mix_mem[mix_waddr] <= in_req_i.coef_value;
    end
    if (gram_we) begin
      gram_mem[gram_waddr] <= in_req_i.coef_value;
    end
    if (pinv_we) begin
      pinv_mem[pinv_waddr] <= in_req_i.coef_value;
    end
    mix_rd_q  <= mix_mem[mix_raddr];
    gram_rd_q <= gram_mem[gram_raddr];
    pinv_rd_q <= pinv_mem[pinv_raddr];
  end

  logic c_last, d_last;
  assign c_last = ({1'b0, c_q} == (KW+1)'(k_eff - KCW'(1)));
  assign d_last = ({1'b0, d_q} == (KW+1)'(k_eff - KCW'(1)));

  // Derived datapath values.
  logic signed [GRAD_W-1:0] term28, g_cur, acc_next;
  logic [30:0]              x_cur;
  logic signed [DW-1:0]     dl;
  logic signed [DW:0]       x_new;
  logic [64:0]              gap_sum;
  logic [63:0]              t_val;
  logic [35:0]              limit;
  logic                     gap_over, keep_going;
  logic [WLCW-1:0]          smp_next;

  assign term28   = prod_q[GRAD_W+27:28];
  assign g_cur    = grad_q[c_q];
  assign x_cur    = sol_q[c_q][30:0];
  assign acc_next = acc_q + term28;
  assign dl       = prod_q[DW+23:24];
  assign x_new    = (DW+1)'(sol_q[c_q]) - (DW+1)'(dh_q) - (DW+1)'(dl);
  assign t_val    = thi_q + 64'(prod_q[PW-1:16]);
  assign gap_sum  = {1'b0, gap_q} + {1'b0, t_val};
  assign limit    = 36'(k_eff) * 36'(gap_tol_q);
  assign gap_over = gap_q > 64'(limit);
  assign keep_going = gap_over && (iter_q < iter_limit_q);
  assign smp_next = WLCW'(w_q) + WLCW'(1);

  // Shared multiplier operand selection.
  logic signed [GRAD_W-1:0] mul_a;
  logic signed [MB_W-1:0]   mul_b;
  always_comb begin
    mul_a = g_cur;
    mul_b = MB_W'($signed({1'b0, step_recip_q[31:16]}));
    case (state_q)
      nnlsgp_pkg::ST_SMP_MA: begin
        mul_a = GRAD_W'(mix_rd_q);
        mul_b = MB_W'(s_q);
      end
      nnlsgp_pkg::ST_SMP_MP: begin
        mul_a = GRAD_W'(pinv_rd_q);
        mul_b = MB_W'(s_q);
      end
      nnlsgp_pkg::ST_GR_MUL: begin
        mul_a = GRAD_W'(gram_rd_q);
        mul_b = $signed({2'b00, sol_q[d_q][30:0]});
      end
      nnlsgp_pkg::ST_GAP_A: begin
        mul_b = $signed({18'd0, x_cur[30:16]});
      end
      nnlsgp_pkg::ST_GAP_B: begin
        mul_b = $signed({17'd0, x_cur[15:0]});
      end
      nnlsgp_pkg::ST_STEP_B: begin
        mul_b = $signed({17'd0, step_recip_q[15:0]});
      end
      default: ;
    endcase
  end

  // The product is registered and consumed in the following state.
  always_ff @(posedge clk_i) begin
    prod_q <= PW'(mul_a) * PW'(mul_b);
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      nnlsgp_pkg::ST_IDLE: begin
        if (in_acc && in_req_i.action == nnlsgp_pkg::ACT_SAMPLE) begin
          state_d = nnlsgp_pkg::ST_SMP_RD;
        end
      end
      nnlsgp_pkg::ST_SMP_RD:  state_d = nnlsgp_pkg::ST_SMP_MA;
      nnlsgp_pkg::ST_SMP_MA:  state_d = nnlsgp_pkg::ST_SMP_MP;
      nnlsgp_pkg::ST_SMP_MP:  state_d = nnlsgp_pkg::ST_SMP_ACC;
      nnlsgp_pkg::ST_SMP_ACC: begin
        if (!c_last) begin
          state_d = nnlsgp_pkg::ST_SMP_RD;
        end else if (smp_next < wl_eff) begin
          state_d = nnlsgp_pkg::ST_IDLE;
        end else begin
          state_d = nnlsgp_pkg::ST_CLIP;
        end
      end
      nnlsgp_pkg::ST_CLIP:   state_d = nnlsgp_pkg::ST_GR_RD;
      nnlsgp_pkg::ST_GR_RD:  state_d = nnlsgp_pkg::ST_GR_MUL;
      nnlsgp_pkg::ST_GR_MUL: state_d = nnlsgp_pkg::ST_GR_ACC;
      nnlsgp_pkg::ST_GR_ACC: begin
        if (d_last && c_last) begin
          state_d = nnlsgp_pkg::ST_GAP_A;
        end else begin
          state_d = nnlsgp_pkg::ST_GR_RD;
        end
      end
      nnlsgp_pkg::ST_GAP_A: begin
        if (g_cur > 0) begin
          state_d = nnlsgp_pkg::ST_GAP_B;
        end else if (c_last) begin
          state_d = nnlsgp_pkg::ST_CHECK;
        end
      end
      nnlsgp_pkg::ST_GAP_B: state_d = nnlsgp_pkg::ST_GAP_C;
      nnlsgp_pkg::ST_GAP_C: begin
        state_d = c_last ? nnlsgp_pkg::ST_CHECK : nnlsgp_pkg::ST_GAP_A;
      end
      nnlsgp_pkg::ST_CHECK: begin
        state_d = keep_going ? nnlsgp_pkg::ST_STEP_A : nnlsgp_pkg::ST_OUT;
      end
      nnlsgp_pkg::ST_STEP_A: state_d = nnlsgp_pkg::ST_STEP_B;
      nnlsgp_pkg::ST_STEP_B: state_d = nnlsgp_pkg::ST_STEP_C;
      nnlsgp_pkg::ST_STEP_C: begin
        state_d = c_last ? nnlsgp_pkg::ST_GR_RD : nnlsgp_pkg::ST_STEP_A;
      end
      nnlsgp_pkg::ST_OUT: begin
        if (out_acc && c_last) begin
          state_d = nnlsgp_pkg::ST_IDLE;
        end
      end
      default: state_d = nnlsgp_pkg::ST_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    in_stall_o  = (state_q != nnlsgp_pkg::ST_IDLE);
    out_valid_o = (state_q == nnlsgp_pkg::ST_OUT);
    out_res_o.abundance       = x_cur;
    out_res_o.component_index = 6'(c_q);
    out_res_o.last_component  = c_last;
    out_res_o.converged       = conv_q;
    out_res_o.iterations_used = iter_q;
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= nnlsgp_pkg::ST_IDLE;
      c_q     <= '0;
      d_q     <= '0;
      smp_q   <= '0;
      w_q     <= '0;
      iter_q  <= '0;
      conv_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      case (state_q)
        nnlsgp_pkg::ST_IDLE: begin
          if (in_acc && in_req_i.action == nnlsgp_pkg::ACT_SAMPLE) begin
            c_q <= '0;
            w_q <= (smp_q >= wl_eff) ? '0 : smp_q[WLW-1:0];
          end
        end
        nnlsgp_pkg::ST_SMP_ACC: begin
          if (!c_last) begin
            c_q <= c_q + KW'(1);
          end else begin
            smp_q <= (smp_next < wl_eff) ? smp_next : '0;
            c_q   <= '0;
            d_q   <= '0;
            iter_q <= '0;
          end
        end
        nnlsgp_pkg::ST_GR_ACC: begin
          if (!d_last) begin
            d_q <= d_q + KW'(1);
          end else begin
            d_q <= '0;
            c_q <= c_last ? '0 : c_q + KW'(1);
          end
        end
        nnlsgp_pkg::ST_GAP_A: begin
          if (!(g_cur > 0) && !c_last) begin
            c_q <= c_q + KW'(1);
          end
        end
        nnlsgp_pkg::ST_GAP_C: begin
          if (!c_last) begin
            c_q <= c_q + KW'(1);
          end
        end
        nnlsgp_pkg::ST_CHECK: begin
          c_q <= '0;
          if (keep_going) begin
            iter_q <= iter_q + 16'd1;
          end else begin
            conv_q <= !gap_over;
          end
        end
        nnlsgp_pkg::ST_STEP_C: begin
          c_q <= c_last ? '0 : c_q + KW'(1);
          d_q <= '0;
        end
        nnlsgp_pkg::ST_OUT: begin
          if (out_acc && !c_last) begin
            c_q <= c_q + KW'(1);
          end
        end
        default: ;
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    case (state_q)
      nnlsgp_pkg::ST_IDLE: begin
        if (in_acc && in_req_i.action == nnlsgp_pkg::ACT_SAMPLE) begin
          s_q <= in_req_i.sample_value;
          // The first sample of a pixel starts both sums from zero.
          if (smp_q >= wl_eff || smp_q == '0) begin
            for (int i = 0; i < MAXK; i++) begin
              corr_q[i] <= '0;
              sol_q[i]  <= '0;
            end
          end
        end
      end
      nnlsgp_pkg::ST_SMP_MP: corr_q[c_q] <= corr_q[c_q] + term28;
      nnlsgp_pkg::ST_SMP_ACC: begin
        sol_q[c_q] <= sol_q[c_q] + term28;
        acc_q <= '0;
      end
      nnlsgp_pkg::ST_CLIP: begin
        for (int i = 0; i < MAXK; i++) begin
          sol_q[i] <= GRAD_W'(nnlsgp_pkg::clip_abund((DW+1)'(sol_q[i])));
        end
      end
      nnlsgp_pkg::ST_GR_ACC: begin
        if (d_last) begin
          grad_q[c_q] <= acc_next - corr_q[c_q];
          acc_q <= '0;
        end else begin
          acc_q <= acc_next;
        end
        gap_q <= '0;
      end
      nnlsgp_pkg::ST_GAP_B: thi_q <= prod_q[63:0];
      nnlsgp_pkg::ST_GAP_C: gap_q <= gap_sum[64] ? '1 : gap_sum[63:0];
      nnlsgp_pkg::ST_STEP_B: dh_q <= prod_q[DW+7:8];
      nnlsgp_pkg::ST_STEP_C: begin
        sol_q[c_q] <= GRAD_W'(nnlsgp_pkg::clip_abund(x_new));
        acc_q <= '0;
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire
